FILE: rtl/core/pft_pkg.sv
// Shared constants for the triangle plane setup pipeline.
package pft_pkg;

    localparam int COORD_W_DEF = 32;
    localparam int NORM_SHIFT  = 30;
    localparam int SM_W        = 31;
    localparam int SQ_W        = 64;
    localparam int LEN_W       = 32;
    localparam int Q_W         = 31;
    localparam int NUM_W       = SM_W + NORM_SHIFT + 1;
    localparam int OUT_W       = 32;
    localparam int SQRT_STAGES = SQ_W / 2;
    localparam int DIV_STAGES  = Q_W;

    localparam logic signed [OUT_W-1:0] UNIT_POS = 32'sh4000_0000;
    localparam logic signed [OUT_W-1:0] UNIT_NEG = -32'sh4000_0000;
    localparam logic signed [63:0] OFF_MAX = 64'sd2147483647;
    localparam logic signed [63:0] OFF_MIN = -64'sd2147483648;

endpackage

FILE: rtl/core/pft_dly.sv
// Fixed-depth register delay line with a shared advance enable.
module pft_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

FILE: rtl/core/pft_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
module pft_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int LA = (AW + 1) / 2;
    localparam int LB = (BW + 1) / 2;
    localparam int HA = AW - LA;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic [AW-1:0]    ma;
    logic [BW-1:0]    mb;
    logic [LA+LB-1:0] ll_reg;
    logic [LA+HB-1:0] lh_reg;
    logic [HA+LB-1:0] hl_reg;
    logic [HA+HB-1:0] hh_reg;
    logic             sg_reg;
    logic [PW-1:0]    mag;
    logic [PW-1:0]    p_reg;

    assign ma = a[AW-1] ? AW'(~a + 1'b1) : AW'(a);
    assign mb = b[BW-1] ? BW'(~b + 1'b1) : BW'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ma[LA-1:0] * mb[LB-1:0];
            lh_reg <= ma[LA-1:0] * mb[BW-1:LB];
            hl_reg <= ma[AW-1:LA] * mb[LB-1:0];
            hh_reg <= ma[AW-1:LA] * mb[BW-1:LB];
            sg_reg <= a[AW-1] ^ b[BW-1];
        end
    end

    assign mag = PW'(ll_reg) + (PW'(lh_reg) << LB) + (PW'(hl_reg) << LA)
               + (PW'(hh_reg) << (LA + LB));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= sg_reg ? PW'(~mag + 1'b1) : mag;
        end
    end

    assign p = signed'(p_reg);

endmodule

FILE: rtl/core/pft_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module pft_sqrt (
    input  logic                     clk,
    input  logic                     en,
    input  logic [pft_pkg::SQ_W-1:0] s,
    output logic [pft_pkg::LEN_W-1:0] len
);

    import pft_pkg::*;

    logic [SQ_W-1:0] n_in  [SQRT_STAGES];
    logic [SQ_W-1:0] r_in  [SQRT_STAGES];
    logic [SQ_W-1:0] n_reg [SQRT_STAGES];
    logic [SQ_W-1:0] r_reg [SQRT_STAGES];

    assign n_in[0] = s;
    assign r_in[0] = '0;

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W:0] trial;

        if (k > 0)
        begin : g_link
            assign n_in[k] = n_reg[k-1];
            assign r_in[k] = r_reg[k-1];
        end

        assign trial = {1'b0, r_in[k]} + {1'b0, BIT};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({1'b0, n_in[k]} >= trial)
                begin
                    n_reg[k] <= n_in[k] - trial[SQ_W-1:0];
                    r_reg[k] <= (r_in[k] >> 1) + BIT;
                end
                else
                begin
                    n_reg[k] <= n_in[k];
                    r_reg[k] <= r_in[k] >> 1;
                end
            end
        end
    end

    assign len = r_reg[SQRT_STAGES-1][LEN_W-1:0];

endmodule

FILE: rtl/core/pft_div.sv
// Pipelined restoring divider for one normal component, one quotient bit per stage.
module pft_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [pft_pkg::SM_W-1:0]  sm,
    input  logic [pft_pkg::LEN_W-1:0] len,
    output logic [pft_pkg::Q_W-1:0]   q
);

    import pft_pkg::*;

    logic [NUM_W-1:0] rem_reg [DIV_STAGES+1];
    logic [LEN_W-1:0] d_reg   [DIV_STAGES+1];
    logic [Q_W-1:0]   q_reg   [DIV_STAGES+1];

    // Numerator carries the rounding term so the quotient rounds to nearest.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= (NUM_W'(sm) << NORM_SHIFT) + NUM_W'(len >> 1);
            d_reg[0]   <= len;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_stage
        localparam int SH = DIV_STAGES - k;
        logic [NUM_W-1:0] dsh;

        assign dsh = NUM_W'(d_reg[k-1]) << SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k] <= d_reg[k-1];
                if (rem_reg[k-1] >= dsh)
                begin
                    rem_reg[k] <= rem_reg[k-1] - dsh;
                    q_reg[k]   <= q_reg[k-1] | (Q_W'(1) << SH);
                end
                else
                begin
                    rem_reg[k] <= rem_reg[k-1];
                    q_reg[k]   <= q_reg[k-1];
                end
            end
        end
    end

    assign q = q_reg[DIV_STAGES];

endmodule

FILE: rtl/core/plane_from_triangle_core.sv
// Top level of the triangle plane equation setup pipeline.
//
// The block takes one triangle per transfer on the s_ stream: nine signed
// Q16.16 vertex coordinates packed in s_tdata. For each triangle it returns
// one transfer on the m_ stream carrying the unit normal in signed Q2.30 and
// the plane offset -(n . v1) in Q16.16, saturated to 32 bits. The m_tuser bit
// flags a degenerate triangle, whose normal and offset are then all zero.
// The block keeps no state between triangles.
//
// A new triangle can be accepted every cycle while the receiver does not
// stall the output. The pipeline depth is set by the 32-stage square root
// and the 32-stage dividers (a load stage plus one stage per quotient
// bit).
//
// Every stage advances together whenever the output register is empty or
// being taken. When the receiver stalls, s_tready drops and the whole
// pipeline holds, so no triangle is lost or repeated. Reset clears all
// valid bits; data registers are not reset.
module plane_from_triangle_core #(
    parameter int COORD_WIDTH = pft_pkg::COORD_W_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z from bit 0 up
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // unit_nx, unit_ny, unit_nz, plane_offset from bit 0 up
    output logic [4*pft_pkg::OUT_W-1:0] m_tdata,
    // degenerate
    output logic [0:0] m_tuser
);

    import pft_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int EW    = W + 1;
    localparam int PW    = 2 * EW;
    localparam int CW    = PW + 1;
    localparam int MW    = PW;
    localparam int TW    = $clog2(MW);
    localparam int DW    = OUT_W + W;
    localparam int ACC_W = DW + 2;
    localparam int RW    = ACC_W - NORM_SHIFT;

    // Register stage at which each value becomes available.
    localparam int ST_IN    = 0;
    localparam int ST_MUL   = ST_IN + 2;
    localparam int ST_CROSS = ST_MUL + 1;
    localparam int ST_TOP   = ST_CROSS + 1;
    localparam int ST_SHIFT = ST_TOP + 1;
    localparam int ST_SQ    = ST_SHIFT + 1;
    localparam int ST_SUM   = ST_SQ + 1;
    localparam int ST_LEN   = ST_SUM + SQRT_STAGES;
    localparam int ST_Q     = ST_LEN + 1 + DIV_STAGES;
    localparam int ST_N     = ST_Q + 1;
    localparam int ST_DOT   = ST_N + 2;
    localparam int ST_ACC   = ST_DOT + 1;
    localparam int ST_OUT   = ST_ACC + 1;
    localparam int LAT      = ST_OUT + 1;

    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (NORM_SHIFT - 1);

    logic                    adv;
    logic                    take;
    logic [LAT-1:0]          vld_reg;
    logic signed [W-1:0]     vin [9];
    logic signed [W-1:0]     p_reg [3];
    logic signed [EW-1:0]    e1_reg [3];
    logic signed [EW-1:0]    e2_reg [3];
    logic signed [PW-1:0]    prod_a [3];
    logic signed [PW-1:0]    prod_b [3];
    logic [MW-1:0]           mag_reg [3];
    logic [2:0]              neg_reg;
    logic [MW-1:0]           mag2_reg [3];
    logic [MW-1:0]           or_mag;
    logic [TW-1:0]           top;
    logic [TW-1:0]           top_reg;
    logic                    deg_reg;
    logic [SM_W-1:0]         sm_reg [3];
    logic [2*SM_W-1:0]       sq_reg [3];
    logic [SQ_W-1:0]         s_reg;
    logic [LEN_W-1:0]        len;
    logic [3*SM_W-1:0]       sm_d;
    logic [Q_W-1:0]          q [3];
    logic [2:0]              neg_d;
    logic signed [OUT_W-1:0] n_reg [3];
    logic [3*W-1:0]          p_d;
    logic signed [DW-1:0]    dot [3];
    logic signed [ACC_W-1:0] acc_reg;
    logic                    deg_d;
    logic [3*OUT_W-1:0]      n_d;
    logic signed [RW-1:0]    rnd;
    logic signed [63:0]      rnd_ext;
    logic [OUT_W-1:0]        off;
    logic [4*OUT_W-1:0]      data_reg;
    logic                    user_reg;

    // One shared advance: the pipeline moves when the output slot frees up.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], take};
        end
    end

    assign m_tvalid = vld_reg[LAT-1];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            vin[i] = s_tdata[i*W +: W];
        end
    end

    // Edge vectors from the first vertex.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i]  <= vin[i];
                e1_reg[i] <= EW'(vin[3+i]) - EW'(vin[i]);
                e2_reg[i] <= EW'(vin[6+i]) - EW'(vin[i]);
            end
        end
    end

    // Cross product terms, component i uses axes i+1 and i+2.
    for (genvar i = 0; i < 3; i++)
    begin : g_cross
        localparam int IA = (i + 1) % 3;
        localparam int IB = (i + 2) % 3;

        pft_mul #(.AW(EW), .BW(EW)) u_mul_a (
            .clk (clk),
            .en  (adv),
            .a   (e1_reg[IA]),
            .b   (e2_reg[IB]),
            .p   (prod_a[i])
        );

        pft_mul #(.AW(EW), .BW(EW)) u_mul_b (
            .clk (clk),
            .en  (adv),
            .a   (e1_reg[IB]),
            .b   (e2_reg[IA]),
            .p   (prod_b[i])
        );
    end

    always_ff @(posedge clk)
    begin
        logic signed [CW-1:0] c;
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c          = CW'(prod_a[i]) - CW'(prod_b[i]);
                neg_reg[i] <= c[CW-1];
                mag_reg[i] <= c[CW-1] ? MW'(-c) : MW'(c);
            end
        end
    end

    // Leading-one position over all three magnitudes.
    assign or_mag = mag_reg[0] | mag_reg[1] | mag_reg[2];

    always_comb
    begin
        top = '0;
        for (int j = 0; j < MW; j++)
        begin
            if (or_mag[j])
            begin
                top = TW'(j);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            top_reg  <= top;
            deg_reg  <= (or_mag == '0);
            mag2_reg <= mag_reg;
        end
    end

    // Scale so the largest magnitude lands in [2^30, 2^31).
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (top_reg > TW'(NORM_SHIFT))
                begin
                    sm_reg[i] <= SM_W'(mag2_reg[i] >> (top_reg - TW'(NORM_SHIFT)));
                end
                else
                begin
                    sm_reg[i] <= SM_W'(mag2_reg[i] << (TW'(NORM_SHIFT) - top_reg));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sm_reg[i] * sm_reg[i];
            end
            s_reg <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
        end
    end

    pft_sqrt u_sqrt (
        .clk (clk),
        .en  (adv),
        .s   (s_reg),
        .len (len)
    );

    pft_dly #(.WIDTH(3*SM_W), .DEPTH(ST_LEN-ST_SHIFT)) u_sm_dly (
        .clk  (clk),
        .en   (adv),
        .din  ({sm_reg[2], sm_reg[1], sm_reg[0]}),
        .dout (sm_d)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        pft_div u_div (
            .clk (clk),
            .en  (adv),
            .sm  (sm_d[i*SM_W +: SM_W]),
            .len (len),
            .q   (q[i])
        );
    end

    pft_dly #(.WIDTH(3), .DEPTH(ST_Q-ST_CROSS)) u_neg_dly (
        .clk  (clk),
        .en   (adv),
        .din  (neg_reg),
        .dout (neg_d)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= neg_d[i] ? -OUT_W'(q[i]) : OUT_W'(q[i]);
            end
        end
    end

    pft_dly #(.WIDTH(3*W), .DEPTH(ST_N-ST_IN)) u_p_dly (
        .clk  (clk),
        .en   (adv),
        .din  ({p_reg[2], p_reg[1], p_reg[0]}),
        .dout (p_d)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        pft_mul #(.AW(OUT_W), .BW(W)) u_mul (
            .clk (clk),
            .en  (adv),
            .a   (n_reg[i]),
            .b   (signed'(p_d[i*W +: W])),
            .p   (dot[i])
        );
    end

    // Negated dot product plus half an output LSB, so the shift rounds.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg <= RND - (ACC_W'(dot[0]) + ACC_W'(dot[1]) + ACC_W'(dot[2]));
        end
    end

    pft_dly #(.WIDTH(1), .DEPTH(ST_ACC-ST_TOP)) u_deg_dly (
        .clk  (clk),
        .en   (adv),
        .din  (deg_reg),
        .dout (deg_d)
    );

    pft_dly #(.WIDTH(3*OUT_W), .DEPTH(ST_ACC-ST_N)) u_n_dly (
        .clk  (clk),
        .en   (adv),
        .din  ({n_reg[2], n_reg[1], n_reg[0]}),
        .dout (n_d)
    );

    assign rnd     = RW'(acc_reg >>> NORM_SHIFT);
    assign rnd_ext = 64'(rnd);

    always_comb
    begin
        if (rnd_ext > OFF_MAX)
        begin
            off = OFF_MAX[OUT_W-1:0];
        end
        else if (rnd_ext < OFF_MIN)
        begin
            off = OFF_MIN[OUT_W-1:0];
        end
        else
        begin
            off = rnd_ext[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= deg_d ? '0 : {off, n_d};
            user_reg <= deg_d;
        end
    end

    assign m_tdata    = data_reg;
    assign m_tuser[0] = user_reg;

    // A degenerate triangle always carries an all-zero normal and offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate result with nonzero payload");

    // Normal components never leave the unit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |->
            $signed(m_tdata[31:0]) <= UNIT_POS && $signed(m_tdata[31:0]) >= UNIT_NEG &&
            $signed(m_tdata[63:32]) <= UNIT_POS && $signed(m_tdata[63:32]) >= UNIT_NEG &&
            $signed(m_tdata[95:64]) <= UNIT_POS && $signed(m_tdata[95:64]) >= UNIT_NEG)
        else $error("unit normal component out of range");

    // While input is refused, no stage may move; this checks the valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule
